[hw/rtl/hkvm_pkg.sv]
// Shared types, constants and helpers for the hex-keypad VM core.
// Used by hkvm_ctrl, hkvm_dp and hex_keypad_vm_cpu_core; no dependencies.
package hkvm_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int AW            = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH   = 16;
  localparam int SPW           = $clog2(STACK_DEPTH);
  localparam int PROGRAM_START = 512;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 96;

  // item kinds carried on in_tuser
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // opcode groups (top nibble)
  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEI  = 4'h3;
  localparam logic [3:0] OPC_SNEI = 4'h4;
  localparam logic [3:0] OPC_SER  = 4'h5;
  localparam logic [3:0] OPC_LDI  = 4'h6;
  localparam logic [3:0] OPC_ADDI = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDIX = 4'hA;
  localparam logic [3:0] OPC_JPV0 = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KK_SKP   = 8'h9E;
  localparam logic [7:0] KK_SKNP  = 8'hA1;
  localparam logic [7:0] KK_GETDT = 8'h07;
  localparam logic [7:0] KK_WKEY  = 8'h0A;
  localparam logic [7:0] KK_SETDT = 8'h15;
  localparam logic [7:0] KK_SETST = 8'h18;
  localparam logic [7:0] KK_ADDI  = 8'h1E;
  localparam logic [7:0] KK_FONT  = 8'h29;
  localparam logic [7:0] KK_BCD   = 8'h33;
  localparam logic [7:0] KK_STORE = 8'h55;
  localparam logic [7:0] KK_LOAD  = 8'h65;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_MEM_WR,
    CMD_FETCH_HI,
    CMD_FETCH_LO,
    CMD_READ_X,
    CMD_READ_Y,
    CMD_EXEC,
    CMD_DRAW_RD,
    CMD_DRAW_XOR,
    CMD_DRAW_END,
    CMD_BCD_WR,
    CMD_STORE_WR,
    CMD_LOAD_RD,
    CMD_LOAD_WR,
    CMD_TIMERS,
    CMD_RESULT
  } hkvm_cmd_t;

  typedef enum logic [2:0] {
    KIND_SIMPLE,
    KIND_DRAW,
    KIND_BCD,
    KIND_STORE,
    KIND_LOAD
  } op_kind_t;

  typedef struct packed {
    hkvm_cmd_t  cmd;
    logic [3:0] cnt;
  } hkvm_ctl_t;

  typedef struct packed {
    logic [1:0] action;
    op_kind_t   kind;
    logic [3:0] x;
    logic [3:0] n;
    logic       row_ok;
  } hkvm_stat_t;

  // decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = v - (8'(hund) * 8'd100);
    prod = 15'(rem[6:0]) * 15'd205;   // rem < 100: (rem*205)>>11 == rem/10
    tens = prod[14:11];
    ones = rem - (8'(tens) * 8'd10);
    case (sel)
      2'd0:    bcd_digit = 8'(hund);
      2'd1:    bcd_digit = 8'(tens);
      default: bcd_digit = ones;
    endcase
  endfunction

endpackage

[hw/rtl/hkvm_ctrl.sv]
// Sequencer for the hex-keypad VM core: one-hot FSM, loop counter, out valid.
// Depends on hkvm_pkg; drives hkvm_dp through hkvm_ctl_t.
module hkvm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output hkvm_pkg::hkvm_ctl_t ctl,
  input  hkvm_pkg::hkvm_stat_t stat
);
  import hkvm_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_DISP     = 17'h00002,
    S_MEMWR    = 17'h00004,
    S_FH       = 17'h00008,
    S_FL       = 17'h00010,
    S_RX       = 17'h00020,
    S_RY       = 17'h00040,
    S_EXEC     = 17'h00080,
    S_DRAW_RD  = 17'h00100,
    S_DRAW_XOR = 17'h00200,
    S_DRAW_END = 17'h00400,
    S_BCD      = 17'h00800,
    S_STORE    = 17'h01000,
    S_LOAD_RD  = 17'h02000,
    S_LOAD_WR  = 17'h04000,
    S_TIMERS   = 17'h08000,
    S_RESULT   = 17'h10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       oval_r, oval_nxt;
  hkvm_cmd_t  cmd;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign ctl.cmd    = cmd;
  assign ctl.cnt    = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = CMD_NONE;
    oval_nxt  = out_tready ? 1'b0 : oval_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.action == ACT_LOAD) state_nxt = S_MEMWR;
        else if (stat.action == ACT_STEP) state_nxt = S_FH;
        else state_nxt = S_RESULT;
      end
      S_MEMWR: begin
        cmd       = CMD_MEM_WR;
        state_nxt = S_RESULT;
      end
      S_FH: begin
        cmd       = CMD_FETCH_HI;
        state_nxt = S_FL;
      end
      S_FL: begin
        cmd       = CMD_FETCH_LO;
        state_nxt = S_RX;
      end
      S_RX: begin
        cmd       = CMD_READ_X;
        state_nxt = S_RY;
      end
      S_RY: begin
        cmd       = CMD_READ_Y;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd     = CMD_EXEC;
        cnt_nxt = '0;
        case (stat.kind)
          KIND_DRAW:  state_nxt = S_DRAW_RD;
          KIND_BCD:   state_nxt = S_BCD;
          KIND_STORE: state_nxt = S_STORE;
          KIND_LOAD:  state_nxt = S_LOAD_RD;
          default:    state_nxt = S_TIMERS;
        endcase
      end
      S_DRAW_RD: begin
        if (cnt_r == stat.n || !stat.row_ok) begin
          state_nxt = S_DRAW_END;
        end else begin
          cmd       = CMD_DRAW_RD;
          state_nxt = S_DRAW_XOR;
        end
      end
      S_DRAW_XOR: begin
        cmd       = CMD_DRAW_XOR;
        cnt_nxt   = cnt_r + 4'd1;
        state_nxt = S_DRAW_RD;
      end
      S_DRAW_END: begin
        cmd       = CMD_DRAW_END;
        state_nxt = S_TIMERS;
      end
      S_BCD: begin
        cmd = CMD_BCD_WR;
        if (cnt_r == 4'd2) state_nxt = S_TIMERS;
        else cnt_nxt = cnt_r + 4'd1;
      end
      S_STORE: begin
        cmd = CMD_STORE_WR;
        if (cnt_r == stat.x) state_nxt = S_TIMERS;
        else cnt_nxt = cnt_r + 4'd1;
      end
      S_LOAD_RD: begin
        cmd       = CMD_LOAD_RD;
        state_nxt = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        cmd = CMD_LOAD_WR;
        if (cnt_r == stat.x) begin
          state_nxt = S_TIMERS;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = S_LOAD_RD;
        end
      end
      S_TIMERS: begin
        cmd       = CMD_TIMERS;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!oval_r || out_tready) begin
          cmd       = CMD_RESULT;
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

[hw/rtl/hkvm_dp.sv]
// Datapath of the hex-keypad VM core: memory, registers, stack, timers, screen.
// Depends on hkvm_pkg; commanded by hkvm_ctrl through hkvm_ctl_t.
module hkvm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hkvm_pkg::hkvm_ctl_t                 ctl,
  output hkvm_pkg::hkvm_stat_t                stat,
  input  logic [hkvm_pkg::IN_USER_W-1:0]      in_user,
  input  logic [hkvm_pkg::IN_DATA_W-1:0]      in_data,
  output logic [hkvm_pkg::OUT_DATA_W-1:0]     out_data
);
  import hkvm_pkg::*;

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rdata_r;

  logic [7:0]  v_r [16];
  logic [15:0] idx_r;
  logic [11:0] pc_r;
  logic [11:0] stk_r [STACK_DEPTH];
  logic [SPW-1:0] sp_r;
  logic [7:0]  dt_r, st_r;
  logic [63:0] scr_r [32];
  logic        chg_r;

  logic [15:0] op_r;
  logic [7:0]  vx_r, vy_r;
  logic        hit_r, bad_r, wait_r;

  logic [1:0]  act_r;
  logic [11:0] addr_r;
  logic [7:0]  dat_r;
  logic [15:0] keys_r;
  logic [7:0]  rnd_r;
  logic [4:0]  row_r;
  logic [OUT_DATA_W-1:0] out_r;

  logic [AW-1:0] maddr;
  logic          mwe;
  logic [7:0]    mwd;
  logic [15:0]   isum;
  logic [3:0]    vra;
  logic [7:0]    vrd;

  assign isum = idx_r + 16'(ctl.cnt);
  assign vrd  = v_r[vra];

  // single memory port: address and write data
  always_comb begin
    maddr = AW'(pc_r);
    mwe   = 1'b0;
    mwd   = vrd;
    case (ctl.cmd)
      CMD_MEM_WR: begin
        maddr = AW'(addr_r);
        mwe   = 1'b1;
        mwd   = dat_r;
      end
      CMD_FETCH_LO: maddr = AW'(pc_r) + AW'(1);
      CMD_DRAW_RD, CMD_LOAD_RD: maddr = isum[AW-1:0];
      CMD_BCD_WR: begin
        maddr = isum[AW-1:0];
        mwe   = 1'b1;
        mwd   = bcd_digit(vx_r, ctl.cnt[1:0]);
      end
      CMD_STORE_WR: begin
        maddr = isum[AW-1:0];
        mwe   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    rdata_r <= mem[maddr];
  end

  // decode helpers
  logic [3:0]  ox, oy, on;
  logic [7:0]  kk;
  logic [11:0] nnn, pc_next, pc_skip;
  assign ox      = op_r[11:8];
  assign oy      = op_r[7:4];
  assign on      = op_r[3:0];
  assign kk      = op_r[7:0];
  assign nnn     = op_r[11:0];
  assign pc_next = pc_r + 12'd2;
  assign pc_skip = pc_r + 12'd4;

  // register file read address
  always_comb begin
    case (ctl.cmd)
      CMD_READ_X: vra = ox;
      CMD_READ_Y: vra = (op_r[15:12] == OPC_JPV0) ? 4'd0 : oy;
      default:    vra = ctl.cnt;
    endcase
  end

  // sprite row geometry
  logic [5:0]  drow;
  logic [63:0] dmask;
  assign drow  = {1'b0, vy_r[4:0]} + 6'(ctl.cnt);
  assign dmask = {rdata_r, 56'd0} >> vx_r[5:0];

  always_comb begin
    stat.action = act_r;
    stat.x      = ox;
    stat.n      = on;
    stat.row_ok = (drow <= 6'd31);
    stat.kind   = KIND_SIMPLE;
    if (op_r[15:12] == OPC_DRW) stat.kind = KIND_DRAW;
    else if (op_r[15:12] == OPC_MISC) begin
      case (kk)
        KK_BCD:   stat.kind = KIND_BCD;
        KK_STORE: stat.kind = KIND_STORE;
        KK_LOAD:  stat.kind = KIND_LOAD;
        default:  stat.kind = KIND_SIMPLE;
      endcase
    end
  end

  // execute: next pc and register writes, applied in CMD_EXEC
  logic [SPW-1:0] sp_inc, sp_dec;
  logic [8:0]  ex_sum;
  logic        key_sel;
  logic [3:0]  key_top;
  logic [11:0] ex_pc;
  logic        ex_vwe, ex_fwe, ex_iwe, ex_bad, ex_wait, ex_cls, ex_call, ex_ret;
  logic        ex_dtwe, ex_stwe;
  logic [7:0]  ex_v, ex_f;
  logic [15:0] ex_i;

  assign sp_inc  = (sp_r == SPW'(STACK_DEPTH - 1)) ? '0 : sp_r + SPW'(1);
  assign sp_dec  = (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - SPW'(1);
  assign ex_sum  = {1'b0, vx_r} + {1'b0, vy_r};
  assign key_sel = keys_r[vx_r[3:0]];

  always_comb begin
    key_top = '0;
    for (int i = 0; i < 16; i++) begin
      if (keys_r[i]) key_top = 4'(i);
    end
  end

  always_comb begin
    ex_pc   = pc_next;
    ex_vwe  = 1'b0;
    ex_v    = '0;
    ex_fwe  = 1'b0;
    ex_f    = '0;
    ex_iwe  = 1'b0;
    ex_i    = '0;
    ex_bad  = 1'b0;
    ex_wait = 1'b0;
    ex_cls  = 1'b0;
    ex_call = 1'b0;
    ex_ret  = 1'b0;
    ex_dtwe = 1'b0;
    ex_stwe = 1'b0;
    case (op_r[15:12])
      OPC_SYS: begin
        if (op_r == OP_CLS) ex_cls = 1'b1;
        else if (op_r == OP_RET) begin
          ex_ret = 1'b1;
          ex_pc  = stk_r[sp_dec];
        end else ex_bad = 1'b1;
      end
      OPC_JP: ex_pc = nnn;
      OPC_CALL: begin
        ex_call = 1'b1;
        ex_pc   = nnn;
      end
      OPC_SEI:  if (vx_r == kk) ex_pc = pc_skip;
      OPC_SNEI: if (vx_r != kk) ex_pc = pc_skip;
      OPC_SER:  if (on == 4'd0 && vx_r == vy_r) ex_pc = pc_skip;
      OPC_SNER: if (on == 4'd0 && vx_r != vy_r) ex_pc = pc_skip;
      OPC_LDI: begin
        ex_vwe = 1'b1;
        ex_v   = kk;
      end
      OPC_ADDI: begin
        ex_vwe = 1'b1;
        ex_v   = vx_r + kk;
      end
      OPC_ALU: begin
        ex_vwe = 1'b1;
        case (on)
          ALU_MOV: ex_v = vy_r;
          ALU_OR:  ex_v = vx_r | vy_r;
          ALU_AND: ex_v = vx_r & vy_r;
          ALU_XOR: ex_v = vx_r ^ vy_r;
          ALU_ADD: begin
            ex_v   = ex_sum[7:0];
            ex_fwe = 1'b1;
            ex_f   = 8'(ex_sum[8]);
          end
          ALU_SUB: begin
            ex_v   = vx_r - vy_r;
            ex_fwe = 1'b1;
            ex_f   = 8'(vx_r > vy_r);
          end
          ALU_SHR: begin
            ex_v   = {1'b0, vy_r[7:1]};
            ex_fwe = 1'b1;
            ex_f   = 8'(vy_r[0]);
          end
          ALU_SUBN: begin
            ex_v   = vy_r - vx_r;
            ex_fwe = 1'b1;
            ex_f   = 8'(vy_r > vx_r);
          end
          ALU_SHL: begin
            ex_v   = {vy_r[6:0], 1'b0};
            ex_fwe = 1'b1;
            ex_f   = 8'(vy_r[7]);
          end
          default: begin
            ex_vwe = 1'b0;
            ex_bad = 1'b1;
          end
        endcase
      end
      OPC_LDIX: begin
        ex_iwe = 1'b1;
        ex_i   = 16'(nnn);
      end
      OPC_JPV0: ex_pc = nnn + 12'(vy_r);   // vy_r holds V0 here
      OPC_RND: begin
        ex_vwe = 1'b1;
        ex_v   = rnd_r & kk;
      end
      OPC_DRW: ;
      OPC_KEY: begin
        if (kk == KK_SKP) begin
          if (key_sel) ex_pc = pc_skip;
        end else if (kk == KK_SKNP) begin
          if (!key_sel) ex_pc = pc_skip;
        end else ex_bad = 1'b1;
      end
      default: begin
        case (kk)
          KK_GETDT: begin
            ex_vwe = 1'b1;
            ex_v   = dt_r;
          end
          KK_WKEY: begin
            if (keys_r == 16'd0) begin
              ex_wait = 1'b1;
              ex_pc   = pc_r;
            end else begin
              ex_vwe = 1'b1;
              ex_v   = 8'(key_top);
            end
          end
          KK_SETDT: ex_dtwe = 1'b1;
          KK_SETST: ex_stwe = 1'b1;
          KK_ADDI: begin
            ex_iwe = 1'b1;
            ex_i   = idx_r + 16'(vx_r);
          end
          KK_FONT: begin
            ex_iwe = 1'b1;
            ex_i   = 16'(vx_r[3:0]) * 16'd5;
          end
          KK_BCD, KK_STORE, KK_LOAD: ;
          default: ex_bad = 1'b1;
        endcase
      end
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_r[i] <= '0;
      for (int i = 0; i < 32; i++) scr_r[i] <= '0;
      idx_r <= '0;
      pc_r  <= 12'(PROGRAM_START);
      sp_r  <= '0;
      dt_r  <= '0;
      st_r  <= '0;
      chg_r <= 1'b0;
    end else begin
      case (ctl.cmd)
        CMD_EXEC: begin
          pc_r <= ex_pc;
          // flag write wins when VF is also the target
          if (ex_vwe && !(ex_fwe && ox == 4'hF)) v_r[ox] <= ex_v;
          if (ex_fwe) v_r[15] <= ex_f;
          if (ex_iwe) idx_r <= ex_i;
          if (ex_dtwe) dt_r <= vx_r;
          if (ex_stwe) st_r <= vx_r;
          if (ex_call) begin
            stk_r[sp_r] <= pc_next;
            sp_r        <= sp_inc;
          end
          if (ex_ret) sp_r <= sp_dec;
          if (ex_cls) begin
            for (int i = 0; i < 32; i++) scr_r[i] <= '0;
            chg_r <= 1'b1;
          end
        end
        CMD_DRAW_XOR: scr_r[drow[4:0]] <= scr_r[drow[4:0]] ^ dmask;
        CMD_DRAW_END: begin
          v_r[15] <= 8'(hit_r);
          chg_r   <= 1'b1;
        end
        CMD_LOAD_WR: v_r[ctl.cnt] <= rdata_r;
        CMD_TIMERS: begin
          if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
          if (st_r != 8'd0) st_r <= st_r - 8'd1;
        end
        CMD_RESULT: if (act_r == ACT_READ) chg_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // per-item working registers and the result word
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_CAPTURE: begin
        act_r  <= in_user;
        addr_r <= in_data[11:0];
        dat_r  <= in_data[19:12];
        keys_r <= in_data[35:20];
        rnd_r  <= in_data[43:36];
        row_r  <= in_data[48:44];
        bad_r  <= 1'b0;
        wait_r <= 1'b0;
        op_r   <= '0;
      end
      CMD_FETCH_LO: op_r[15:8] <= rdata_r;
      CMD_READ_X: begin
        op_r[7:0] <= rdata_r;
        vx_r      <= vrd;
      end
      CMD_READ_Y: vy_r <= vrd;
      CMD_EXEC: begin
        bad_r  <= ex_bad;
        wait_r <= ex_wait;
        hit_r  <= 1'b0;
      end
      CMD_DRAW_XOR: if ((scr_r[drow[4:0]] & dmask) != 64'd0) hit_r <= 1'b1;
      CMD_RESULT: begin
        out_r <= {(act_r == ACT_READ) ? scr_r[row_r] : 64'd0,
                  wait_r, bad_r, (st_r != 8'd0), chg_r,
                  (act_r == ACT_STEP) ? op_r : 16'd0,
                  pc_r};
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

[hw/rtl/hex_keypad_vm_cpu_core.sv]
// Top level of the hex-keypad VM core (classic instruction set; 0nnn SYS flags bad_opcode).
// Depends on hkvm_pkg, hkvm_ctrl (sequencer) and hkvm_dp (datapath).
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  in      | in  | in_tvalid/in_tready | in_tuser: action; in_tdata: load/step/read
//  out     | out | out_tvalid/tready   | out_tdata: pc, opcode, flags, screen row
//
// One word at a time. Load: capture, dispatch, memory write, result; read or idle:
// capture, dispatch, result; step: fetch, read Vx and Vy, execute, timers, result.
// The single-port 4 KB memory paces fetch, sprite and block moves (DRW, Fx33/55/65).
// Reset (rst_n low, synchronous) clears registers, stack, timers and screen;
// pc goes to 0x200; memory contents stay undefined until loaded.
// The result sits in an output register; a stalled out_tready holds it while the
// next word is taken in, and the core waits only when a second result is ready.
module hex_keypad_vm_cpu_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] action
  input  logic [hkvm_pkg::IN_USER_W-1:0]     in_tuser,
  // [11:0] address, [19:12] data, [35:20] keys, [43:36] random_byte, [48:44] row
  input  logic [hkvm_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [11:0] program_counter, [27:12] opcode, [28] draw_flag, [29] sound_on,
  // [30] bad_opcode, [31] waiting_key, [95:32] screen_row
  output logic [hkvm_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import hkvm_pkg::*;

  hkvm_ctl_t  ctl;
  hkvm_stat_t stat;

  hkvm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .stat       (stat)
  );

  hkvm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .stat     (stat),
    .in_user  (in_tuser),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

endmodule
